@@ src/aigs_pkg.sv @@
// shared types and constants for the and-inverter graph simulator
`timescale 1ns / 1ps

package aigs_pkg;

   localparam int TYPE_BITS = 2;
   localparam int ID_BITS   = 12;
   localparam int WORD_BITS = 64;

   typedef enum logic [TYPE_BITS-1:0] {
      KIND_LOAD = 2'd0,
      KIND_AND  = 2'd1,
      KIND_BUF  = 2'd2,
      KIND_READ = 2'd3
   } req_kind_type;

   // per-fanin source select for the evaluation stage
   typedef struct packed {
      logic a_zero;
      logic a_hit;
      logic b_zero;
      logic b_hit;
   } fanin_sel_type;

endpackage

@@ src/aig_bit_parallel_simulator.sv @@
// top level of the bit-parallel and-inverter graph simulator
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  req     | in        | req_valid / req_stall | req_type, node and fanin ids, inverts, word
//  rsp     | out       | rsp_valid / rsp_stall | rsp_node_word
//
// after accept an item passes through the memory read, then evaluate and write back, into the result register
// one item per cycle is sustained while rsp_stall stays low; the single write port and one forwarding register set it
// a fanin written by the item just ahead is forwarded from that register
// reset clears only the control state; the word store is undefined until written
// req_stall rises only while the evaluated item waits on a stalled result register
`timescale 1ns / 1ps

module aig_bit_parallel_simulator
   import aigs_pkg::*;
#(
   parameter int MAX_NODES    = 4096,
   parameter int PATTERN_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [TYPE_BITS-1:0] req_type,
   input  logic [ID_BITS-1:0]   req_node_id,
   input  logic [ID_BITS-1:0]   req_fanin_a_id,
   input  logic                 req_fanin_a_invert,
   input  logic [ID_BITS-1:0]   req_fanin_b_id,
   input  logic                 req_fanin_b_invert,
   input  logic [WORD_BITS-1:0] req_load_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_node_word
);

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int PB = PATTERN_BITS;

   // handshake
   logic accept;
   logic advance;

   // ids widened so that the address and range check follow MAX_NODES
   logic [31:0]   node_wide;
   logic [31:0]   a_wide;
   logic [31:0]   b_wide;
   req_kind_type  kind_req;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;

   // evaluation stage
   logic          s1_valid_ff, s1_valid_in;
   req_kind_type  s1_kind_ff;
   logic          s1_a_inv_ff;
   logic          s1_b_inv_ff;
   logic [PB-1:0] s1_load_ff;
   logic [AW-1:0] s1_node_addr_ff;
   logic          s1_node_ok_ff;
   logic [AW-1:0] s1_a_addr_ff;
   logic          s1_a_ok_ff;
   logic [AW-1:0] s1_b_addr_ff;
   logic          s1_b_ok_ff;

   // last write, kept for the item right behind it
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic [PB-1:0] fwd_word_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_word_ff;

   logic [PB-1:0] rd_a;
   logic [PB-1:0] rd_b;
   logic [PB-1:0] eval_word;
   fanin_sel_type sel;
   logic          wr_en;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign kind_req  = req_kind_type'(req_type);
   assign node_wide = 32'(req_node_id);
   // a read item looks up its own node on port a
   assign a_wide    = (kind_req == KIND_READ) ? 32'(req_node_id) : 32'(req_fanin_a_id);
   assign b_wide    = 32'(req_fanin_b_id);
   assign rd_addr_a = a_wide[AW-1:0];
   assign rd_addr_b = b_wide[AW-1:0];

   aigs_word_mem #(
      .DEPTH (MAX_NODES),
      .AW    (AW),
      .DW    (PB)
   ) u_mem (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b),
      .wr_en     (wr_en),
      .wr_addr   (s1_node_addr_ff),
      .wr_data   (eval_word)
   );

   // out-of-range fanins read as zero; otherwise a hit takes the last written word from the forwarding register
   assign sel.a_zero = !s1_a_ok_ff;
   assign sel.a_hit  = fwd_valid_ff && (fwd_addr_ff == s1_a_addr_ff);
   assign sel.b_zero = !s1_b_ok_ff;
   assign sel.b_hit  = fwd_valid_ff && (fwd_addr_ff == s1_b_addr_ff);

   aigs_eval #(
      .DW (PB)
   ) u_eval (
      .kind      (s1_kind_ff),
      .a_invert  (s1_a_inv_ff),
      .b_invert  (s1_b_inv_ff),
      .sel       (sel),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .fwd_word  (fwd_word_ff),
      .load_word (s1_load_ff),
      .word      (eval_word)
   );

   // write back for every item but a read, and only inside the store
   assign wr_en = advance && (s1_kind_ff != KIND_READ) && s1_node_ok_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            fwd_valid_ff <= wr_en;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff      <= kind_req;
         s1_a_inv_ff     <= (kind_req != KIND_READ) && req_fanin_a_invert;
         s1_b_inv_ff     <= req_fanin_b_invert;
         s1_load_ff      <= req_load_word[PB-1:0];
         s1_node_addr_ff <= node_wide[AW-1:0];
         s1_node_ok_ff   <= node_wide < 32'(MAX_NODES);
         s1_a_addr_ff    <= rd_addr_a;
         s1_a_ok_ff      <= a_wide < 32'(MAX_NODES);
         s1_b_addr_ff    <= rd_addr_b;
         s1_b_ok_ff      <= b_wide < 32'(MAX_NODES);
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_node_addr_ff;
         fwd_word_ff <= eval_word;
      end
      if (advance) begin
         rsp_word_ff <= WORD_BITS'(eval_word);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_node_word = rsp_word_ff;

   // an accepted item always occupies the evaluation stage next cycle
   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item did not reach evaluation stage");

   // a store write always leaves its word in the forwarding register
   a_fwd_tracks_write : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> fwd_valid_ff && (fwd_addr_ff == $past(s1_node_addr_ff))
                && (fwd_word_ff == $past(eval_word)))
      else $error("forwarding register does not match last write");

   // reads never write the store
   a_read_no_write : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s1_valid_ff && (s1_kind_ff != KIND_READ))
      else $error("store written by a read item or an empty stage");

   // an evaluated item shows up as the result on the next cycle
   a_result_loaded : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid && (rsp_node_word == WORD_BITS'($past(eval_word))))
      else $error("result register missed an evaluated item");

endmodule

@@ src/aigs_word_mem.sv @@
// node word store: two registered read ports, one write port
`timescale 1ns / 1ps

module aigs_word_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 64
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [DW-1:0] rd_data_a,
   output logic [DW-1:0] rd_data_b,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] words_ff [DEPTH];
   logic [DW-1:0] rd_a_ff;
   logic [DW-1:0] rd_b_ff;

   // read returns the old word when the same entry is written in that cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= words_ff[rd_addr_a];
         rd_b_ff <= words_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ src/aigs_eval.sv @@
// fanin select, forwarding, inversion and node function
`timescale 1ns / 1ps

module aigs_eval
   import aigs_pkg::*;
#(
   parameter int DW = 64
) (
   input  req_kind_type  kind,
   input  logic          a_invert,
   input  logic          b_invert,
   input  fanin_sel_type sel,
   input  logic [DW-1:0] rd_a,
   input  logic [DW-1:0] rd_b,
   input  logic [DW-1:0] fwd_word,
   input  logic [DW-1:0] load_word,
   output logic [DW-1:0] word
);

   logic [DW-1:0] a_word;
   logic [DW-1:0] b_word;

   always_comb begin
      if (sel.a_zero) begin
         a_word = '0;
      end else if (sel.a_hit) begin
         a_word = fwd_word;
      end else begin
         a_word = rd_a;
      end
      if (sel.b_zero) begin
         b_word = '0;
      end else if (sel.b_hit) begin
         b_word = fwd_word;
      end else begin
         b_word = rd_b;
      end
      a_word = a_word ^ {DW{a_invert}};
      b_word = b_word ^ {DW{b_invert}};
   end

   always_comb begin
      unique case (kind)
         KIND_LOAD: word = load_word;
         KIND_AND:  word = a_word & b_word;
         KIND_BUF:  word = a_word;
         KIND_READ: word = a_word;
         default:   word = a_word;
      endcase
   end

endmodule

@@ test/node_word_track_pkg.sv @@
// scoreboard class that predicts and checks the simulator's node words
`timescale 1ns / 1ps

package node_word_track_pkg;
   import aigs_pkg::*;

   class node_word_tracker;
      // shadow copy of the node word store
      logic [WORD_BITS-1:0] node_words [1 << ID_BITS];
      bit                   is_written [1 << ID_BITS];
      logic [ID_BITS-1:0]   written_ids [$];
      logic [ID_BITS-1:0]   recent_ids [$];
      logic [WORD_BITS-1:0] expected_words [$];
      int                   failures;
      int                   words_checked;

      function logic [WORD_BITS-1:0] fanin_word(logic [ID_BITS-1:0] id, logic invert);
         return invert ? ~node_words[id] : node_words[id];
      endfunction

      // called once per accepted item, in acceptance order
      function void note_item(req_kind_type kind, logic [ID_BITS-1:0] node_id,
                              logic [ID_BITS-1:0] a_id, logic a_inv,
                              logic [ID_BITS-1:0] b_id, logic b_inv,
                              logic [WORD_BITS-1:0] load_word);
         logic [WORD_BITS-1:0] word;
         case (kind)
            KIND_LOAD: word = load_word;
            KIND_AND:  word = fanin_word(a_id, a_inv) & fanin_word(b_id, b_inv);
            KIND_BUF:  word = fanin_word(a_id, a_inv);
            default:   word = node_words[node_id];
         endcase
         // fanins above were read before this write, so self fanin sees the old word
         if (kind != KIND_READ) begin
            if (!is_written[node_id]) written_ids = {written_ids, node_id};
            is_written[node_id] = 1'b1;
            node_words[node_id] = word;
            recent_ids.push_front(node_id);
            if (recent_ids.size() > 4) void'(recent_ids.pop_back());
         end
         expected_words = {expected_words, word};
      endfunction

      function void check_word(logic [WORD_BITS-1:0] actual);
         logic [WORD_BITS-1:0] expected;
         if (expected_words.size() == 0) begin
            $error("node_word %h returned with nothing pending", actual);
            failures++;
            return;
         end
         expected = expected_words.pop_front();
         words_checked++;
         if (actual !== expected) begin
            $error("node_word mismatch: expected %h, actual %h", expected, actual);
            failures++;
         end
      endfunction
   endclass

endpackage

@@ test/testbench.sv @@
// self-checking testbench for the bit-parallel and-inverter graph simulator
`timescale 1ns / 1ps

module testbench;
   import aigs_pkg::*;
   import node_word_track_pkg::*;

   localparam int RANDOM_ITEMS = 1450;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 150;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [TYPE_BITS-1:0] req_type = KIND_LOAD;
   logic [ID_BITS-1:0]   req_node_id = '0;
   logic [ID_BITS-1:0]   req_fanin_a_id = '0;
   logic                 req_fanin_a_invert = 1'b0;
   logic [ID_BITS-1:0]   req_fanin_b_id = '0;
   logic                 req_fanin_b_invert = 1'b0;
   logic [WORD_BITS-1:0] req_load_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [WORD_BITS-1:0] rsp_node_word;

   node_word_tracker tracker = new();
   int               kind_count [4];
   int               cycle_count = 0;

   aig_bit_parallel_simulator uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_node_id        (req_node_id),
      .req_fanin_a_id     (req_fanin_a_id),
      .req_fanin_a_invert (req_fanin_a_invert),
      .req_fanin_b_id     (req_fanin_b_id),
      .req_fanin_b_invert (req_fanin_b_invert),
      .req_load_word      (req_load_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_node_word      (rsp_node_word)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // present one item and hold it until the block takes it; valid is left high
   task automatic send_node(req_kind_type kind, logic [ID_BITS-1:0] node_id,
                            logic [ID_BITS-1:0] a_id, logic a_inv,
                            logic [ID_BITS-1:0] b_id, logic b_inv,
                            logic [WORD_BITS-1:0] load_word);
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_node_id        <= node_id;
      req_fanin_a_id     <= a_id;
      req_fanin_a_invert <= a_inv;
      req_fanin_b_id     <= b_id;
      req_fanin_b_invert <= b_inv;
      req_load_word      <= load_word;
      // accepted at the first edge where stall is low
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_item(kind, node_id, a_id, a_inv, b_id, b_inv, load_word);
      kind_count[kind]++;
   endtask

   // pick an id that already holds a word, often one written just before
   // so the forwarding path gets exercised
   function automatic logic [ID_BITS-1:0] pick_known_id();
      if ($urandom_range(0, 1) == 0)
         return tracker.recent_ids[$urandom_range(0, tracker.recent_ids.size() - 1)];
      return tracker.written_ids[$urandom_range(0, tracker.written_ids.size() - 1)];
   endfunction

   // result side: check every accepted word, then pick the next stall value
   initial begin
      int hold_left;
      int next_hold_at;
      int segment_left;
      int stall_mode;
      logic next_stall;
      hold_left    = 0;
      next_hold_at = 300;
      segment_left = 0;
      stall_mode   = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            tracker.check_word(rsp_node_word);
         // long hold-off so the pipeline fills and the sender gets stalled
         if (hold_left == 0 && tracker.words_checked >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + 600;
         end
         if (segment_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            segment_left = $urandom_range(20, 80);
         end
         segment_left--;
         if (hold_left > 0) begin
            next_stall = 1'b1;
            hold_left--;
         end else begin
            case (stall_mode)
               0:       next_stall = 1'b0;                        // free flowing
               1:       next_stall = ($urandom_range(0, 3) == 0); // light stalls
               2:       next_stall = ($urandom_range(0, 9) < 7);  // heavy stalls
               default: next_stall = !rsp_stall;                  // alternating stall
            endcase
         end
         rsp_stall <= next_stall;
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int                   burst_left;
      int                   gap;
      int                   pick;
      req_kind_type         kind;
      logic [ID_BITS-1:0]   node_id;
      logic [ID_BITS-1:0]   a_id;
      logic [ID_BITS-1:0]   b_id;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part, back to back; unused fields carry extreme values
      // all-zero and all-one words at the lowest and highest node ids, alternating-bit words at ids 1 and 2, then reads
      send_node(KIND_LOAD, 12'd0, 12'hFFF, 1'b1, 12'hFFF, 1'b1, 64'h0);
      send_node(KIND_LOAD, 12'hFFF, 12'd0, 1'b0, 12'd0, 1'b0, '1);
      send_node(KIND_LOAD, 12'd1, 12'hFFF, 1'b1, 12'd0, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
      send_node(KIND_LOAD, 12'd2, 12'd0, 1'b0, 12'hFFF, 1'b1, 64'h5555_5555_5555_5555);
      send_node(KIND_READ, 12'd0, 12'hFFF, 1'b1, 12'hFFF, 1'b1, '1);
      send_node(KIND_READ, 12'hFFF, 12'd0, 1'b0, 12'd0, 1'b0, 64'h0);
      // every invert combination on the and node
      send_node(KIND_AND, 12'd3, 12'd0, 1'b0, 12'hFFF, 1'b0, '1);
      send_node(KIND_AND, 12'd4, 12'd0, 1'b1, 12'hFFF, 1'b0, 64'h0);
      send_node(KIND_AND, 12'd5, 12'd1, 1'b1, 12'd2, 1'b1, 64'h0);
      send_node(KIND_AND, 12'd6, 12'd1, 1'b0, 12'd2, 1'b1, 64'h0);
      // output buffers, plain and inverted; fanin b is ignored
      send_node(KIND_BUF, 12'd7, 12'hFFF, 1'b1, 12'hFFF, 1'b1, '1);
      send_node(KIND_BUF, 12'd8, 12'd1, 1'b0, 12'd0, 1'b0, '1);
      // self fanin reads the word held before the item's own write
      send_node(KIND_AND, 12'd1, 12'd1, 1'b0, 12'd2, 1'b1, 64'h0);
      send_node(KIND_BUF, 12'd2, 12'd2, 1'b1, 12'hFFF, 1'b0, 64'h0);
      send_node(KIND_READ, 12'd1, 12'd0, 1'b0, 12'd0, 1'b0, 64'h0);
      send_node(KIND_READ, 12'd2, 12'd0, 1'b0, 12'd0, 1'b0, 64'h0);
      // chain through the item just ahead and three ahead
      send_node(KIND_LOAD, 12'd9, 12'd0, 1'b0, 12'd0, 1'b0, 64'h8000_0000_0000_0001);
      send_node(KIND_AND, 12'd10, 12'd9, 1'b0, 12'd9, 1'b1, 64'h0);
      send_node(KIND_BUF, 12'd11, 12'd10, 1'b1, 12'd0, 1'b0, 64'h0);
      send_node(KIND_AND, 12'd12, 12'd11, 1'b0, 12'd9, 1'b0, 64'h0);
      send_node(KIND_LOAD, 12'hFFF, 12'd0, 1'b0, 12'd0, 1'b0, 64'h8000_0000_0000_0001);
      send_node(KIND_READ, 12'hFFF, 12'd0, 1'b0, 12'd0, 1'b0, 64'h0);
      send_node(KIND_READ, 12'd12, 12'd0, 1'b0, 12'd0, 1'b0, 64'h0);

      // random part: graphs built in topological order, bursts with or without gaps between
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;

         pick = $urandom_range(0, 99);
         if (pick < 25)      kind = KIND_LOAD;
         else if (pick < 60) kind = KIND_AND;
         else if (pick < 78) kind = KIND_BUF;
         else                kind = KIND_READ;

         // fields an item does not use stay random
         a_id    = ID_BITS'($urandom_range(0, 4095));
         b_id    = ID_BITS'($urandom_range(0, 4095));
         node_id = ID_BITS'($urandom_range(0, 4095));
         if (kind == KIND_AND || kind == KIND_BUF) begin
            a_id = pick_known_id();
            b_id = (kind == KIND_AND) ? pick_known_id() : b_id;
            // occasionally write over a fanin of the same item
            if ($urandom_range(0, 9) == 0) node_id = ($urandom_range(0, 1) == 0) ? a_id : b_id;
         end else if (kind == KIND_READ) begin
            node_id = pick_known_id();
         end
         send_node(kind, node_id, a_id, 1'($urandom_range(0, 1)), b_id,
                   1'($urandom_range(0, 1)), {$urandom(), $urandom()});
      end
      req_valid <= 1'b0;

      // drain, then wait for any stray result
      while (tracker.expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d items: %0d loads, %0d and nodes, %0d buffers, %0d reads",
               kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
               kind_count[KIND_LOAD], kind_count[KIND_AND], kind_count[KIND_BUF],
               kind_count[KIND_READ]);
      $display("%0d node words checked under random and long result stalls",
               tracker.words_checked);
      if (tracker.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
